[design/tcgr_pkg.sv]
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and sizes of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	// Grid and glyph store geometry
	localparam int GRID_COLS   = 64;
	localparam int GRID_ROWS   = 32;
	localparam int GLYPH_MAX_W = 32;
	localparam int GLYPH_MAX_H = 32;
	localparam int COL_W       = $clog2(GRID_COLS);
	localparam int ROW_W       = $clog2(GRID_ROWS);
	localparam int CELL_AW     = COL_W + ROW_W;
	localparam int CELLS       = GRID_COLS * GRID_ROWS;

	localparam int FIRST_CODE  = 32;
	localparam int FIRST_DRAWN = 33;
	localparam int LAST_CODE   = 126;
	localparam int LF_CODE     = 10;
	localparam int NUM_GLYPHS  = LAST_CODE - FIRST_CODE + 1;
	localparam int GLYPH_AW    = $clog2(NUM_GLYPHS);
	localparam int LINE_AW     = $clog2(GLYPH_MAX_H);
	localparam int GROWS_AW    = GLYPH_AW + LINE_AW;
	localparam int GROWS       = NUM_GLYPHS * GLYPH_MAX_H;

	// Configuration port
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_MARGIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd7;

	localparam logic [7:0] ALPHA = 8'h80;

	// Pixel position divider: dividend bits
	localparam int DIV_N = 11;

	typedef enum logic [2:0] {
		OP_PUT     = 3'd0,
		OP_SETPOS  = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_METRICS = 3'd3,
		OP_ROW     = 3'd4,
		OP_QUERY   = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [5:0] dx;
		logic signed [5:0] dy;
		logic        [5:0] w;
		logic        [5:0] h;
	} metric_t;

endpackage

[design/text_console_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Character cell console: cursor, cell grid, glyph store and pixel lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in channel (in_valid/in_stall); each gives exactly
//   one result on the out channel (out_valid/out_stall): the pixel colour
//   (zero except for a pixel query) and the cursor after the command.
//   Configuration is to be written through cfg_we/cfg_index/cfg_data only
//   while idle; the block itself does not enforce this. A pixel query runs
//   an 11-bit restoring division (one quotient bit a cycle), then walks the
//   nine neighbour cells through the cell, metric and glyph row memories; a
//   clear walks the 2048-entry cell memory one entry a cycle. One command
//   is worked on at a time; the next is taken as soon as the result sits in
//   the output register, even if it is not yet taken. After reset the cell
//   memory is cleared in a pass over all 2048 entries during which in_stall
//   is high; configuration writes are taken throughout. A stalled result
//   holds in the output register; work stops in the done state until the
//   register frees.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcgr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         opcode,
	input  logic [7:0]                         code,
	input  logic signed [10:0]                 x_coord,
	input  logic signed [10:0]                 y_coord,
	input  logic signed [5:0]                  glyph_dx,
	input  logic signed [5:0]                  glyph_dy,
	input  logic [5:0]                         glyph_width,
	input  logic [5:0]                         glyph_height,
	input  logic [4:0]                         glyph_line,
	input  logic [31:0]                        line_bits,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [31:0]                        pixel_color,
	output logic [5:0]                         cursor_col,
	output logic [4:0]                         cursor_row
);
	import tcgr_pkg::*;

	localparam int DIV_CW = $clog2(DIV_N);
	localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_N - 1);
	localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);

	// Configuration registers
	logic [5:0]  left_margin_q, top_margin_q, cell_width_q, cell_height_q;
	logic [6:0]  max_cols_q;
	logic [5:0]  max_rows_q;
	logic [23:0] bg_color_q, fg_color_q;

	// Control
	state_t state_q, state_d;
	logic   in_xfer, out_free, out_load;
	logic   glyph_ok;
	logic [CELL_AW-1:0] clr_cnt_q;

	// Cursor and result
	logic [COL_W-1:0] cursor_x_q;
	logic [ROW_W-1:0] cursor_y_q;
	logic [31:0]      pix_q;
	logic             out_vld_q;
	logic [31:0]      out_pix_q;
	logic [5:0]       out_col_q;
	logic [4:0]       out_row_q;

	// Memories
	logic [6:0]  cell_mem [0:CELLS-1];
	metric_t     met_mem [0:NUM_GLYPHS-1];
	logic [31:0] grow_mem [0:GROWS-1];
	logic [6:0]  cell_rd_q;
	metric_t     met_rd_q;
	logic [31:0] grow_rd_q;
	logic               cell_we;
	logic [CELL_AW-1:0] cell_wa, cell_ra;
	logic [6:0]         cell_wd;

	// Divider
	logic [DIV_CW-1:0] div_cnt_q;
	logic [DIV_N-1:0]  dn_x_q, dn_y_q, dq_x_q, dq_y_q;
	logic [5:0]        dr_x_q, dr_y_q;
	logic              neg_x_q, neg_y_q;
	logic signed [10:0] px_q, py_q;

	// Neighbour scan
	logic [1:0] kx_q, ky_q;
	logic       iss_done_q, iss_vld, hit_q, scan_end;
	logic vld_s1, inr_s1, vld_s2, ok_s2, vld_s3, hok_s3;
	logic [COL_W-1:0]    cx_s1;
	logic [ROW_W-1:0]    cy_s1;
	logic [GLYPH_AW-1:0] g_s2;
	logic [11:0]         orgx_s2, orgy_s2;
	logic [4:0]          lx_s3;

	// Derived limits
	logic [6:0] cols_used;
	logic [5:0] rows_used;
	logic [5:0] cw_eff, ch_eff;

	assign cols_used = (max_cols_q > 7'(GRID_COLS)) ? 7'(GRID_COLS) :
		(max_cols_q == 7'd0) ? 7'd1 : max_cols_q;
	assign rows_used = (max_rows_q > 6'(GRID_ROWS)) ? 6'(GRID_ROWS) :
		(max_rows_q == 6'd0) ? 6'd1 : max_rows_q;
	assign cw_eff = (cell_width_q == 6'd0) ? 6'd1 : cell_width_q;
	assign ch_eff = (cell_height_q == 6'd0) ? 6'd1 : cell_height_q;

	assign glyph_ok = (code >= 8'(FIRST_CODE)) && (code <= 8'(LAST_CODE));

	// One restoring division step: {quotient bit, new remainder}
	function automatic logic [6:0] div_step(input logic [5:0] rem, input logic msb,
		input logic [5:0] dvs);
		logic [6:0] t;
		begin
			t = {rem, msb};
			if (t >= {1'b0, dvs}) begin
				div_step = {1'b1, 6'(t - {1'b0, dvs})};
			end else begin
				div_step = {1'b0, t[5:0]};
			end
		end
	endfunction

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		out_free = !out_vld_q || !out_stall;
		out_load = 1'b0;
		case (state_q)
			ST_INIT: begin
				if (clr_cnt_q == CELL_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (opcode_t'(opcode))
						OP_CLEAR: state_d = ST_CLEAR;
						OP_QUERY: state_d = ST_DIV;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (clr_cnt_q == CELL_LAST) state_d = ST_DONE;
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				out_load = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_margin_q <= 6'd4;
			top_margin_q  <= 6'd4;
			cell_width_q  <= 6'd8;
			cell_height_q <= 6'd16;
			max_cols_q    <= 7'd64;
			max_rows_q    <= 6'd32;
			bg_color_q    <= 24'h303030;
			fg_color_q    <= 24'hA0A0A0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_MARGIN: left_margin_q <= cfg_data[5:0];
				CFG_TOP_MARGIN:  top_margin_q  <= cfg_data[5:0];
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[5:0];
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data[5:0];
				CFG_MAX_COLS:    max_cols_q    <= cfg_data[6:0];
				CFG_MAX_ROWS:    max_rows_q    <= cfg_data[5:0];
				CFG_BG_COLOR:    bg_color_q    <= cfg_data;
				CFG_FG_COLOR:    fg_color_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Cell memory write select: clearing pass or stored byte
	always_comb begin
		cell_we = 1'b0;
		cell_wa = clr_cnt_q;
		cell_wd = 7'd0;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			cell_we = 1'b1;
		end else if (in_xfer && opcode_t'(opcode) == OP_PUT && glyph_ok) begin
			cell_we = 1'b1;
			cell_wa = {cursor_y_q, cursor_x_q};
			cell_wd = code[6:0];
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end else begin
			clr_cnt_q <= '0;
		end
	end

	// Cursor update and immediate result
	logic [6:0] nx;
	logic [5:0] ny;
	logic [5:0] sp_x;
	logic [4:0] sp_y;
	always_comb begin
		nx = {1'b0, cursor_x_q} + 7'd1;
		ny = {1'b0, cursor_y_q} + 6'd1;
		if (x_coord[10]) begin
			sp_x = 6'd0;
		end else if ({1'b0, x_coord[9:0]} >= {4'd0, cols_used}) begin
			sp_x = 6'(cols_used - 7'd1);
		end else begin
			sp_x = x_coord[5:0];
		end
		if (y_coord[10]) begin
			sp_y = 5'd0;
		end else if ({1'b0, y_coord[9:0]} >= {5'd0, rows_used}) begin
			sp_y = 5'(rows_used - 6'd1);
		end else begin
			sp_y = y_coord[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (in_xfer) begin
			case (opcode_t'(opcode))
				OP_PUT: begin
					if ((glyph_ok && nx >= cols_used) || (!glyph_ok && code == 8'(LF_CODE))) begin
						cursor_x_q <= '0;
						cursor_y_q <= (ny >= rows_used) ? ROW_W'(rows_used - 6'd1) : ny[4:0];
					end else if (glyph_ok) begin
						cursor_x_q <= nx[5:0];
					end
				end
				OP_SETPOS: begin
					cursor_x_q <= sp_x;
					cursor_y_q <= sp_y;
				end
				OP_CLEAR: begin
					cursor_x_q <= '0;
					cursor_y_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Glyph store and cell memory ports
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd_q <= cell_mem[cell_ra];
	end

	logic [GLYPH_AW-1:0] g_s1;
	logic                ok_s1;
	always_ff @(posedge clk) begin
		if (in_xfer && opcode_t'(opcode) == OP_METRICS && glyph_ok) begin
			met_mem[GLYPH_AW'(code - 8'(FIRST_CODE))] <=
				'{dx: glyph_dx, dy: glyph_dy, w: glyph_width, h: glyph_height};
		end
		met_rd_q <= met_mem[ok_s1 ? g_s1 : '0];
	end

	logic [GROWS_AW-1:0] grow_ra;
	always_ff @(posedge clk) begin
		if (in_xfer && opcode_t'(opcode) == OP_ROW && glyph_ok &&
			{1'b0, glyph_line} < 6'(GLYPH_MAX_H)) begin
			grow_mem[{GLYPH_AW'(code - 8'(FIRST_CODE)), LINE_AW'(glyph_line)}] <= line_bits;
		end
		grow_rd_q <= grow_mem[grow_ra];
	end

	// Pixel cell search: divide pixel offsets by the cell size
	logic signed [11:0] ax, ay;
	logic [6:0] stx, sty;
	assign ax  = {x_coord[10], x_coord} - {6'd0, left_margin_q};
	assign ay  = {y_coord[10], y_coord} - {6'd0, top_margin_q};
	assign stx = div_step(dr_x_q, dn_x_q[DIV_N-1], cw_eff);
	assign sty = div_step(dr_y_q, dn_y_q[DIV_N-1], ch_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end else begin
			div_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && opcode_t'(opcode) == OP_QUERY) begin
			px_q    <= x_coord;
			py_q    <= y_coord;
			neg_x_q <= ax[11];
			neg_y_q <= ay[11];
			dn_x_q  <= ax[11] ? ~ax[DIV_N-1:0] : ax[DIV_N-1:0];
			dn_y_q  <= ay[11] ? ~ay[DIV_N-1:0] : ay[DIV_N-1:0];
			dr_x_q  <= '0;
			dr_y_q  <= '0;
		end else if (state_q == ST_DIV) begin
			dn_x_q <= dn_x_q << 1;
			dn_y_q <= dn_y_q << 1;
			dr_x_q <= stx[5:0];
			dr_y_q <= sty[5:0];
			dq_x_q <= {dq_x_q[DIV_N-2:0], stx[6]};
			dq_y_q <= {dq_y_q[DIV_N-2:0], sty[6]};
		end
	end

	// Floor quotient: negative offsets give ~(|a|-1)/b
	logic signed [11:0] col, row;
	logic signed [12:0] cx, cy;
	logic               inr;
	assign col = neg_x_q ? ~{1'b0, dq_x_q} : {1'b0, dq_x_q};
	assign row = neg_y_q ? ~{1'b0, dq_y_q} : {1'b0, dq_y_q};
	assign cx  = {col[11], col} + {11'd0, kx_q} - 13'sd1;
	assign cy  = {row[11], row} + {11'd0, ky_q} - 13'sd1;
	assign inr = !cx[12] && !cy[12] && (cx[11:0] < {5'd0, cols_used}) &&
		(cy[11:0] < {6'd0, rows_used});
	assign cell_ra  = {cy[ROW_W-1:0], cx[COL_W-1:0]};
	assign iss_vld  = (state_q == ST_SCAN) && !iss_done_q;
	assign scan_end = iss_done_q && !vld_s1 && !vld_s2 && !vld_s3;

	// Stage 1: cell code back, look up metrics and cell origin
	assign ok_s1 = inr_s1 && (cell_rd_q >= 7'(FIRST_DRAWN)) && (cell_rd_q <= 7'(LAST_CODE));
	assign g_s1  = GLYPH_AW'(cell_rd_q - 7'(FIRST_CODE));

	// Stage 2: metrics back, local pixel position, fetch glyph row
	logic signed [13:0] lx, ly;
	logic [5:0]         w_c, h_c;
	logic               hok;
	assign lx  = {{3{px_q[10]}}, px_q} - {2'd0, orgx_s2} -
		{{8{met_rd_q.dx[5]}}, met_rd_q.dx};
	assign ly  = {{3{py_q[10]}}, py_q} - {2'd0, orgy_s2} -
		{{8{met_rd_q.dy[5]}}, met_rd_q.dy};
	assign w_c = (met_rd_q.w > 6'(GLYPH_MAX_W)) ? 6'(GLYPH_MAX_W) : met_rd_q.w;
	assign h_c = (met_rd_q.h > 6'(GLYPH_MAX_H)) ? 6'(GLYPH_MAX_H) : met_rd_q.h;
	assign hok = ok_s2 && !lx[13] && !ly[13] && (lx[12:0] < {7'd0, w_c}) &&
		(ly[12:0] < {7'd0, h_c});
	assign grow_ra = hok ? {g_s2, ly[LINE_AW-1:0]} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			iss_done_q <= 1'b0;
			kx_q       <= '0;
			ky_q       <= '0;
			hit_q      <= 1'b0;
		end else begin
			vld_s1 <= iss_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			// Step over the 3x3 neighbourhood
			if (state_q == ST_DIV) begin
				kx_q       <= '0;
				ky_q       <= '0;
				iss_done_q <= 1'b0;
				hit_q      <= 1'b0;
			end else if (iss_vld) begin
				if (kx_q == 2'd2) begin
					kx_q <= '0;
					if (ky_q == 2'd2) iss_done_q <= 1'b1;
					else ky_q <= ky_q + 2'd1;
				end else begin
					kx_q <= kx_q + 2'd1;
				end
			end
			// Stage 3: glyph row back, test the pixel bit
			if (vld_s3 && hok_s3 && grow_rd_q[lx_s3]) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		inr_s1  <= inr;
		cx_s1   <= cx[COL_W-1:0];
		cy_s1   <= cy[ROW_W-1:0];
		ok_s2   <= ok_s1;
		g_s2    <= ok_s1 ? g_s1 : '0;
		orgx_s2 <= {6'd0, left_margin_q} + 12'(cx_s1 * cw_eff);
		orgy_s2 <= {6'd0, top_margin_q} + 12'({1'b0, cy_s1} * ch_eff);
		hok_s3  <= hok;
		lx_s3   <= lx[4:0];
	end

	// Result colour
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q <= '0;
		end else if (state_q == ST_SCAN && scan_end) begin
			pix_q <= {ALPHA, hit_q ? fg_color_q : bg_color_q};
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q <= pix_q;
			out_col_q <= cursor_x_q;
			out_row_q <= cursor_y_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign pixel_color = out_pix_q;
	assign cursor_col  = out_col_q;
	assign cursor_row  = out_row_q;

`ifndef NO_ASSERTIONS
	a_scan_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2 || vld_s3) |-> state_q == ST_SCAN)
		else $error("neighbour pipeline busy outside scan");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_cnt_q <= DIV_LAST)
		else $error("divider step count overrun");

	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && $past(state_q) == ST_IDLE) |->
		(clr_cnt_q == '0 && cursor_x_q == '0 && cursor_y_q == '0))
		else $error("clear pass started with stale counter or cursor");
`endif

endmodule

[tb/sv/text_console_glyph_renderer_test.sv]
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_test
// Drives console commands with random idling on both channels. An internal
// console model predicts each result, and every result is checked against it.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tcgr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [31:0] pixel;
		logic [5:0]  col;
		logic [4:0]  row;
	} console_result_t;

	typedef struct {
		int dx;
		int dy;
		int w;
		int h;
	} glyph_shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [7:0] code = '0;
	logic signed [10:0] x_coord = '0;
	logic signed [10:0] y_coord = '0;
	logic signed [5:0] glyph_dx = '0;
	logic signed [5:0] glyph_dy = '0;
	logic [5:0] glyph_width = '0;
	logic [5:0] glyph_height = '0;
	logic [4:0] glyph_line = '0;
	logic [31:0] line_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] pixel_color;
	logic [5:0] cursor_col;
	logic [4:0] cursor_row;

	text_console_glyph_renderer DUT (.*);

	always #6 clk = ~clk;

	// Console model state
	int reg_file [8];
	logic [6:0] grid [GRID_ROWS][GRID_COLS];
	glyph_shape_t shapes [NUM_GLYPHS];
	logic [31:0] bitmaps [NUM_GLYPHS][GLYPH_MAX_H];
	bit shape_loaded [NUM_GLYPHS];
	bit row_loaded [NUM_GLYPHS][GLYPH_MAX_H];
	int cur_x, cur_y;

	console_result_t expected_results [$];
	int failures = 0;
	int stall_cycles = 0;
	bit idling_on = 1'b1;
	int idle_cycles = 0;

	function automatic int sx(input logic [31:0] v, input int bits);
		int r;
		r = v & ((1 << bits) - 1);
		if (r >= (1 << (bits - 1)))
			r -= (1 << bits);
		return r;
	endfunction

	function automatic int cols_in_use();
		int c;
		c = reg_file[CFG_MAX_COLS] > GRID_COLS ? GRID_COLS : reg_file[CFG_MAX_COLS];
		return c == 0 ? 1 : c;
	endfunction

	function automatic int rows_in_use();
		int r;
		r = reg_file[CFG_MAX_ROWS] > GRID_ROWS ? GRID_ROWS : reg_file[CFG_MAX_ROWS];
		return r == 0 ? 1 : r;
	endfunction

	// Number of glyph rows loaded without a gap from the top
	function automatic int rows_ready(input int g);
		int n;
		n = 0;
		while (n < GLYPH_MAX_H && row_loaded[g][n])
			n++;
		return n;
	endfunction

	function automatic int div_down(input int a, input int b);
		int q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic void next_line();
		cur_x = 0;
		cur_y++;
		if (cur_y >= rows_in_use())
			cur_y = rows_in_use() - 1;
	endfunction

	function automatic bit cell_covers(input int cx, input int cy, input int px, input int py);
		int cw, ch, c, g, w, h, lx, ly;
		cw = reg_file[CFG_CELL_WIDTH] ? reg_file[CFG_CELL_WIDTH] : 1;
		ch = reg_file[CFG_CELL_HEIGHT] ? reg_file[CFG_CELL_HEIGHT] : 1;
		if (cx < 0 || cy < 0 || cx >= cols_in_use() || cy >= rows_in_use())
			return 1'b0;
		c = grid[cy][cx];
		if (c < FIRST_DRAWN || c > LAST_CODE)
			return 1'b0;
		g = c - FIRST_CODE;
		w = shapes[g].w > GLYPH_MAX_W ? GLYPH_MAX_W : shapes[g].w;
		h = shapes[g].h > GLYPH_MAX_H ? GLYPH_MAX_H : shapes[g].h;
		lx = px - (reg_file[CFG_LEFT_MARGIN] + cx * cw + shapes[g].dx);
		ly = py - (reg_file[CFG_TOP_MARGIN] + cy * ch + shapes[g].dy);
		if (lx < 0 || ly < 0 || lx >= w || ly >= h)
			return 1'b0;
		return bitmaps[g][ly][lx];
	endfunction

	// Work out the result of one command and advance the console model
	function automatic console_result_t console_step(input logic [2:0] op, input logic [7:0] ch,
			input int xc, input int yc, input int dx, input int dy, input int w, input int h,
			input int line, input logic [31:0] bits);
		console_result_t r;
		bit printable;
		int col, row, cw, chh;
		bit hit;
		printable = ch >= FIRST_CODE && ch <= LAST_CODE;
		r.pixel = '0;
		case (op)
			OP_PUT: begin
				if (printable) begin
					if (cur_y < GRID_ROWS && cur_x < GRID_COLS)
						grid[cur_y][cur_x] = ch[6:0];
					cur_x++;
					if (cur_x >= cols_in_use())
						next_line();
				end else if (ch == LF_CODE) begin
					next_line();
				end
			end
			OP_SETPOS: begin
				if (xc < 0) xc = 0;
				if (xc >= cols_in_use()) xc = cols_in_use() - 1;
				if (yc < 0) yc = 0;
				if (yc >= rows_in_use()) yc = rows_in_use() - 1;
				cur_x = xc;
				cur_y = yc;
			end
			OP_CLEAR: begin
				foreach (grid[i, j])
					grid[i][j] = '0;
				cur_x = 0;
				cur_y = 0;
			end
			OP_METRICS: begin
				if (printable) begin
					shapes[ch - FIRST_CODE] = '{dx, dy, w, h};
					shape_loaded[ch - FIRST_CODE] = 1'b1;
				end
			end
			OP_ROW: begin
				if (printable && line < GLYPH_MAX_H) begin
					bitmaps[ch - FIRST_CODE][line] = bits;
					row_loaded[ch - FIRST_CODE][line] = 1'b1;
				end
			end
			OP_QUERY: begin
				cw = reg_file[CFG_CELL_WIDTH] ? reg_file[CFG_CELL_WIDTH] : 1;
				chh = reg_file[CFG_CELL_HEIGHT] ? reg_file[CFG_CELL_HEIGHT] : 1;
				col = div_down(xc - reg_file[CFG_LEFT_MARGIN], cw);
				row = div_down(yc - reg_file[CFG_TOP_MARGIN], chh);
				hit = 1'b0;
				for (int ddy = -1; ddy <= 1; ddy++)
					for (int ddx = -1; ddx <= 1; ddx++)
						if (cell_covers(col + ddx, row + ddy, xc, yc))
							hit = 1'b1;
				r.pixel = {ALPHA, hit ? reg_file[CFG_FG_COLOR][23:0] : reg_file[CFG_BG_COLOR][23:0]};
			end
			default: ;
		endcase
		r.col = cur_x[5:0];
		r.row = cur_y[4:0];
		return r;
	endfunction

	// Send one command and queue its prediction; valid stays high until a later idle gap or drain drops it
	task automatic send_command(input logic [2:0] op, input logic [7:0] ch = 8'd0,
			input int xc = 0, input int yc = 0, input int dx = 0, input int dy = 0,
			input int w = 0, input int h = 0, input int line = 0, input logic [31:0] bits = 0);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		opcode <= op;
		code <= ch;
		x_coord <= xc;
		y_coord <= yc;
		glyph_dx <= dx;
		glyph_dy <= dy;
		glyph_width <= w;
		glyph_height <= h;
		glyph_line <= line;
		line_bits <= bits;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(console_step(op, ch, xc, yc, dx, dy, w, h, line, bits));
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		reg_file[idx] = value;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Load a glyph: metrics plus its top rows
	task automatic load_glyph(input logic [7:0] ch, input int dx, input int dy,
			input int w, input int h, input int lines);
		send_command(OP_METRICS, ch, 0, 0, dx, dy, w, h);
		for (int i = 0; i < lines; i++)
			send_command(OP_ROW, ch, 0, 0, 0, 0, 0, 0, i, $urandom);
	endtask

	task automatic test_glyph_load();
		int gh;
		// Extremes first, then all the rest at random; rows below the height are never read
		load_glyph(8'd33, -32, -32, 32, 32, GLYPH_MAX_H);
		load_glyph(8'd126, 31, 31, 63, 63, GLYPH_MAX_H);
		load_glyph(8'd65, 0, 0, 0, 0, 0);
		for (int c = FIRST_CODE; c <= LAST_CODE; c++)
			if (!shape_loaded[c - FIRST_CODE]) begin
				gh = $urandom_range(1, 4);
				load_glyph(c, sx($urandom, 4), sx($urandom, 4), $urandom_range(1, 16),
					gh, gh);
			end
		// Codes and lines that are ignored
		send_command(OP_METRICS, 8'd31, 0, 0, 5, 5, 5, 5);
		send_command(OP_METRICS, 8'd127, 0, 0, 5, 5, 5, 5);
		send_command(OP_ROW, 8'd255, 0, 0, 0, 0, 0, 0, 31, 32'hFFFFFFFF);
		send_command(OP_ROW, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
	endtask

	task automatic test_directed();
		send_command(OP_PUT, 8'd33);
		send_command(OP_PUT, 8'd126);
		send_command(OP_PUT, 8'd32);
		send_command(OP_PUT, 8'd10);
		send_command(OP_PUT, 8'd0);
		send_command(OP_PUT, 8'd255);
		send_command(OP_PUT, 8'd127);
		send_command(OP_SETPOS, 0, -1024, -1024);
		send_command(OP_SETPOS, 0, 1023, 1023);
		send_command(OP_PUT, 8'd65);
		send_command(OP_PUT, 8'd10);
		send_command(OP_SETPOS, 0, 62, 3);
		send_command(OP_PUT, 8'd66);
		send_command(OP_PUT, 8'd67);
		send_command(OP_QUERY, 0, -1024, -1024);
		send_command(OP_QUERY, 0, 1023, 1023);
		send_command(OP_QUERY, 0, 6, 6);
		send_command(3'd6);
		send_command(3'd7);
		send_command(OP_CLEAR);
		send_command(OP_QUERY, 0, 6, 6);
	endtask

	task automatic random_phase(input int count);
		int pick, qx, qy, cw, ch, gc, hmax;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			cw = reg_file[CFG_CELL_WIDTH] ? reg_file[CFG_CELL_WIDTH] : 1;
			ch = reg_file[CFG_CELL_HEIGHT] ? reg_file[CFG_CELL_HEIGHT] : 1;
			if (pick < 40) begin
				send_command(OP_PUT, $urandom_range(0, 5) == 0 ?
					($urandom_range(0, 1) ? 8'd10 : 8'($urandom)) : 8'($urandom_range(32, 126)));
			end else if (pick < 48) begin
				send_command(OP_SETPOS, 0, $urandom_range(0, 3) == 0 ? sx($urandom, 11) :
					$urandom_range(0, 70), $urandom_range(0, 3) == 0 ? sx($urandom, 11) :
					$urandom_range(0, 35));
			end else if (pick < 50) begin
				send_command(OP_ROW, $urandom_range(32, 126), 0, 0, 0, 0, 0, 0,
					$urandom_range(0, 31), $urandom);
			end else if (pick < 52) begin
				// Keep the height within the rows already loaded
				gc = $urandom_range(FIRST_CODE, LAST_CODE);
				hmax = rows_ready(gc - FIRST_CODE);
				if (hmax == GLYPH_MAX_H)
					hmax = 63;
				send_command(OP_METRICS, gc, 0, 0, sx($urandom, 6),
					sx($urandom, 6), $urandom_range(0, 63), $urandom_range(0, hmax));
			end else if (pick < 53 && $urandom_range(0, 3) == 0) begin
				send_command(OP_CLEAR);
			end else if (pick < 55) begin
				send_command($urandom_range(6, 7), $urandom, sx($urandom, 11), sx($urandom, 11));
			end else begin
				// Query mostly near the drawn text
				if ($urandom_range(0, 7) == 0) begin
					qx = sx($urandom, 11);
					qy = sx($urandom, 11);
				end else begin
					qx = reg_file[CFG_LEFT_MARGIN] + $urandom_range(0, cw * 12) - 4;
					qy = reg_file[CFG_TOP_MARGIN] + $urandom_range(0, ch * 6) - 4;
				end
				send_command(OP_QUERY, $urandom, qx, qy);
			end
		end
	endtask

	task automatic test_settings();
		int geometry [5][6] = '{
			'{0, 0, 1, 1, 1, 1},
			'{63, 63, 32, 32, 64, 32},
			'{2, 3, 0, 0, 0, 0},
			'{10, 1, 5, 7, 127, 63},
			'{4, 4, 8, 16, 12, 6}};
		for (int s = 0; s < 5; s++) begin
			wait_drained();
			for (int r = 0; r < 6; r++)
				write_register(r, geometry[s][r]);
			write_register(CFG_BG_COLOR, s == 0 ? 0 : (s == 1 ? 24'hFFFFFF : $urandom));
			write_register(CFG_FG_COLOR, s == 0 ? 24'hFFFFFF : (s == 1 ? 0 : $urandom));
			@(negedge clk);
			cfg_we <= 1'b0;
			send_command(OP_CLEAR);
			random_phase(200);
		end
		wait_drained();
		idling_on = 1'b0;
		random_phase(80);
	endtask

	// Receiver idling
	always @(negedge clk) begin
		if (stall_cycles > 0) begin
			stall_cycles--;
			out_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 9) == 0) begin
			stall_cycles = $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each transfer with the oldest prediction
	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result pixel_color %h", pixel_color);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (pixel_color !== want.pixel) begin
					$error("pixel_color expected %h actual %h", want.pixel, pixel_color);
					failures++;
				end
				if (cursor_col !== want.col) begin
					$error("cursor_col expected %0d actual %0d", want.col, cursor_col);
					failures++;
				end
				if (cursor_row !== want.row) begin
					$error("cursor_row expected %0d actual %0d", want.row, cursor_row);
					failures++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer; allow for the clearing pass
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		reg_file = '{4, 4, 8, 16, 64, 32, 3158064, 10526880};
		foreach (grid[i, j])
			grid[i][j] = '0;
		cur_x = 0;
		cur_y = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_glyph_load();
		test_directed();
		test_settings();
		wait_drained();
		if (failures == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[sim.f]
design/tcgr_pkg.sv
design/text_console_glyph_renderer.sv
tb/sv/text_console_glyph_renderer_test.sv
